[hw/rtl/seglcd_pkg.sv]
// Shared types, constants and lookup tables of the segment LCD driver.
`default_nettype none

package seglcd_pkg;

    // Defaults for the top-level parameters
    localparam int DIGIT_COUNT_DEF = 6;
    localparam int IMAGE_BYTES_DEF = 20;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Binary to decimal conversion: two magnitude bits are consumed per cycle
    localparam int NUMBER_BITS    = 32;
    localparam int BITS_PER_CYCLE = 2;
    localparam int CONV_CYCLES    = NUMBER_BITS / BITS_PER_CYCLE;
    localparam int BCD_DIGITS     = 6;
    localparam int BCD_BITS       = 4 * BCD_DIGITS;

    // Sign segment of the integer display
    localparam logic [4:0] SIGN_BYTE = 5'd11;
    localparam int         SIGN_BIT  = 2;
    localparam logic [7:0] SIGN_MASK = 8'(1 << SIGN_BIT);

    // Offsets of the character ranges into the pattern table
    localparam logic [7:0] LOWER_OFFSET = 8'd87;
    localparam logic [7:0] UPPER_OFFSET = 8'd55;
    localparam logic [7:0] DIGIT_OFFSET = 8'd48;

    localparam logic [5:0] GLYPH_BLANK = 6'd36;
    localparam int         INDICATORS  = 16;

    typedef enum logic [1:0] {
        OP_CLEAR     = 2'd0,
        OP_CHAR      = 2'd1,
        OP_NUMBER    = 2'd2,
        OP_INDICATOR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_CHAR,
        KIND_NUMBER,
        KIND_IND
    } kind_t;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_CONVERT,
        FRONT_PUSH
    } front_state_t;

    // One classified command handed from the front to the back
    typedef struct packed {
        kind_t                 kind;
        logic [2:0]            position;
        logic [5:0]            glyph;
        logic [BCD_BITS-1:0]   bcd;
        logic [2:0]            count;
        logic                  neg;
        logic [4:0]            ind_addr;
        logic [2:0]            ind_bit;
        logic                  ind_on;
    } cmd_t;

    // Two pattern bytes of a digit or letter, first byte in the upper half
    function automatic logic [15:0] glyph_pattern(input logic [5:0] idx);
        logic [15:0] pat;
        unique case (idx)
            6'd0:    pat = 16'hFC28;
            6'd1:    pat = 16'h6020;
            6'd2:    pat = 16'hDB00;
            6'd3:    pat = 16'hF300;
            6'd4:    pat = 16'h6700;
            6'd5:    pat = 16'hB700;
            6'd6:    pat = 16'hBF00;
            6'd7:    pat = 16'hE400;
            6'd8:    pat = 16'hFF00;
            6'd9:    pat = 16'hF700;
            6'd10:   pat = 16'hEF00;
            6'd11:   pat = 16'hF150;
            6'd12:   pat = 16'h9C00;
            6'd13:   pat = 16'hF050;
            6'd14:   pat = 16'h9F00;
            6'd15:   pat = 16'h8F00;
            6'd16:   pat = 16'hBD00;
            6'd17:   pat = 16'h6F00;
            6'd18:   pat = 16'h9050;
            6'd19:   pat = 16'h7800;
            6'd20:   pat = 16'h0E22;
            6'd21:   pat = 16'h1C00;
            6'd22:   pat = 16'h6CA0;
            6'd23:   pat = 16'h6C82;
            6'd24:   pat = 16'hFC00;
            6'd25:   pat = 16'hCF00;
            6'd26:   pat = 16'hFC02;
            6'd27:   pat = 16'hCF02;
            6'd28:   pat = 16'hB700;
            6'd29:   pat = 16'h8050;
            6'd30:   pat = 16'h7C00;
            6'd31:   pat = 16'h0C28;
            6'd32:   pat = 16'h6C0A;
            6'd33:   pat = 16'h00AA;
            6'd34:   pat = 16'h00B0;
            6'd35:   pat = 16'h9028;
            default: pat = 16'h0000;
        endcase
        return pat;
    endfunction

    // First LCD byte of a character position
    function automatic logic [4:0] pos_byte(input logic [2:0] pos);
        logic [4:0] addr;
        unique case (pos)
            3'd1:    addr = 5'd10;
            3'd2:    addr = 5'd6;
            3'd3:    addr = 5'd4;
            3'd4:    addr = 5'd19;
            3'd5:    addr = 5'd15;
            3'd6:    addr = 5'd8;
            default: addr = 5'd0;
        endcase
        return addr;
    endfunction

    function automatic logic [4:0] ind_byte(input logic [3:0] idx);
        logic [4:0] addr;
        unique case (idx)
            4'd0, 4'd1:                  addr = 5'd9;
            4'd2, 4'd10:                 addr = 5'd5;
            4'd3, 4'd4, 4'd5, 4'd6:      addr = 5'd3;
            4'd7, 4'd8:                  addr = 5'd11;
            4'd9, 4'd13:                 addr = 5'd7;
            4'd11, 4'd14:                addr = 5'd20;
            default:                     addr = 5'd16;
        endcase
        return addr;
    endfunction

    function automatic logic [2:0] ind_bit(input logic [3:0] idx);
        logic [2:0] b;
        unique case (idx)
            4'd0, 4'd2, 4'd3, 4'd7, 4'd13, 4'd14, 4'd15: b = 3'd2;
            4'd5:                                        b = 3'd3;
            4'd6:                                        b = 3'd1;
            default:                                     b = 3'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/seglcd_front.sv]
// Front end: accepts input beats, classifies them and converts integers to decimal.
`default_nettype none

module seglcd_front #(
    parameter int DIGIT_COUNT = seglcd_pkg::DIGIT_COUNT_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [1:0]          opcode,
    input  wire logic [2:0]          position,
    input  wire logic [7:0]          code,
    input  wire logic signed [31:0]  number,
    input  wire logic                indicator_on,
    output logic                     q_push,
    output seglcd_pkg::cmd_t         q_data,
    input  wire logic                q_full
);

    localparam int CNT_W = $clog2(seglcd_pkg::CONV_CYCLES);
    localparam int BB    = seglcd_pkg::BCD_BITS;

    seglcd_pkg::front_state_t state_reg, state_next;

    logic [seglcd_pkg::NUMBER_BITS-1:0] mag_reg;
    logic [BB-1:0]                      bcd_reg;
    logic                               big_reg;
    logic                               neg_reg;
    logic [CNT_W-1:0]                   cnt_reg;

    logic                               accept;
    logic                               load;
    seglcd_pkg::cmd_t                   direct_cmd;
    logic                               direct_valid;
    logic [5:0]                         glyph_idx;
    logic [BB:0]                        step_a;
    logic [BB:0]                        step_b;
    logic [2:0]                         ndigits;
    logic [2:0]                         count;

    // One shift-and-add-three step; the bit shifted out of the top digit is returned
    function automatic logic [BB:0] dabble(input logic [BB-1:0] bcd, input logic in_bit);
        logic [BB-1:0] fixed;
        fixed = bcd;
        for (int i = 0; i < seglcd_pkg::BCD_DIGITS; i++) begin
            if (bcd[4*i +: 4] >= 4'd5) begin
                fixed[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return {fixed, in_bit};
    endfunction

    assign accept = push && !full;
    assign full   = (state_reg != seglcd_pkg::FRONT_IDLE) || q_full;

    always_comb
    begin
        if (code >= 8'h61 && code <= 8'h7A) begin
            glyph_idx = 6'(code - seglcd_pkg::LOWER_OFFSET);
        end else if (code >= 8'h41 && code <= 8'h5A) begin
            glyph_idx = 6'(code - seglcd_pkg::UPPER_OFFSET);
        end else if (code >= 8'h30 && code <= 8'h39) begin
            glyph_idx = 6'(code - seglcd_pkg::DIGIT_OFFSET);
        end else begin
            glyph_idx = seglcd_pkg::GLYPH_BLANK;
        end
    end

    always_comb
    begin
        direct_cmd   = '0;
        direct_valid = 1'b0;
        unique case (seglcd_pkg::op_t'(opcode))
            seglcd_pkg::OP_CLEAR:
            begin
                direct_cmd.kind = seglcd_pkg::KIND_CLEAR;
                direct_valid    = 1'b1;
            end
            seglcd_pkg::OP_CHAR:
            begin
                direct_cmd.kind     = seglcd_pkg::KIND_CHAR;
                direct_cmd.position = position;
                direct_cmd.glyph    = glyph_idx;
                direct_valid        = (position >= 3'd1) && (position <= 3'd6);
            end
            seglcd_pkg::OP_NUMBER:
            begin
                direct_cmd.kind = seglcd_pkg::KIND_NUMBER;
            end
            seglcd_pkg::OP_INDICATOR:
            begin
                direct_cmd.kind     = seglcd_pkg::KIND_IND;
                direct_cmd.ind_addr = seglcd_pkg::ind_byte(code[3:0]);
                direct_cmd.ind_bit  = seglcd_pkg::ind_bit(code[3:0]);
                direct_cmd.ind_on   = indicator_on;
                direct_valid        = (code < 8'(seglcd_pkg::INDICATORS));
            end
        endcase
    end

    // Digits shown, at most DIGIT_COUNT: all six once the magnitude reached a million, else
    // the significant ones, at least one so that zero shows a single 0.
    always_comb
    begin
        ndigits = 3'd1;
        for (int i = 1; i < seglcd_pkg::BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0) begin
                ndigits = 3'(i + 1);
            end
        end
        if (big_reg) begin
            ndigits = 3'(seglcd_pkg::BCD_DIGITS);
        end
        count = (ndigits > 3'(DIGIT_COUNT)) ? 3'(DIGIT_COUNT) : ndigits;
    end

    always_comb
    begin
        state_next = state_reg;
        q_push     = 1'b0;
        q_data     = direct_cmd;
        load       = 1'b0;
        unique case (state_reg)
            seglcd_pkg::FRONT_IDLE:
            begin
                if (accept) begin
                    if (seglcd_pkg::op_t'(opcode) == seglcd_pkg::OP_NUMBER) begin
                        load       = 1'b1;
                        state_next = seglcd_pkg::FRONT_CONVERT;
                    end else begin
                        q_push = direct_valid;
                    end
                end
            end
            seglcd_pkg::FRONT_CONVERT:
            begin
                if (cnt_reg == CNT_W'(seglcd_pkg::CONV_CYCLES - 1)) begin
                    state_next = seglcd_pkg::FRONT_PUSH;
                end
            end
            seglcd_pkg::FRONT_PUSH:
            begin
                // The converted integer waits here while the queue is full.
                q_data       = '0;
                q_data.kind  = seglcd_pkg::KIND_NUMBER;
                q_data.bcd   = bcd_reg;
                q_data.count = count;
                q_data.neg   = neg_reg;
                if (!q_full) begin
                    q_push     = 1'b1;
                    state_next = seglcd_pkg::FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = seglcd_pkg::FRONT_IDLE;
            end
        endcase
    end

    assign step_a = dabble(bcd_reg, mag_reg[seglcd_pkg::NUMBER_BITS-1]);
    assign step_b = dabble(step_a[BB-1:0], mag_reg[seglcd_pkg::NUMBER_BITS-2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= seglcd_pkg::FRONT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            neg_reg <= number[31];
            mag_reg <= number[31] ? (32'd0 - number) : number;
            bcd_reg <= '0;
            big_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (state_reg == seglcd_pkg::FRONT_CONVERT) begin
            mag_reg <= {mag_reg[seglcd_pkg::NUMBER_BITS-3:0], 2'b00};
            bcd_reg <= step_b[BB-1:0];
            big_reg <= big_reg | step_a[BB] | step_b[BB];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/seglcd_cmd_queue.sv]
// Short command queue between the front end and the back end.
`default_nettype none

module seglcd_cmd_queue #(
    parameter int DEPTH = seglcd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire seglcd_pkg::cmd_t  push_data,
    output logic                   full,
    input  wire logic              pop,
    output seglcd_pkg::cmd_t       head,
    output logic                   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    seglcd_pkg::cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/seglcd_back.sv]
// Back end: holds the LCD image and issues one byte write per cycle while commands wait and the output is not held.
`default_nettype none

module seglcd_back #(
    parameter int IMAGE_BYTES = seglcd_pkg::IMAGE_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire seglcd_pkg::cmd_t  head,
    input  wire logic              q_empty,
    output logic                   q_pop,
    output logic                   empty,
    input  wire logic              pop,
    output logic [4:0]             byte_address,
    output logic [7:0]             byte_value,
    output logic                   clear_all,
    output logic                   last_write
);

    localparam int IDX_W = $clog2(IMAGE_BYTES);

    logic [7:0]  image_reg [IMAGE_BYTES];
    logic [3:0]  step_reg;
    logic        out_valid_reg;
    logic [4:0]  addr_reg;
    logic [7:0]  value_reg;
    logic        clear_reg;
    logic        last_reg;

    logic        emit;
    logic [4:0]  addr;
    logic [7:0]  value;
    logic        clr;
    logic        last;
    logic [15:0] pattern;
    logic [5:0]  glyph;
    logic [2:0]  char_pos;
    logic [2:0]  digit_idx;
    logic [7:0]  current;
    logic [7:0]  ind_mask;

    assign emit      = !q_empty && (!out_valid_reg || pop);
    assign q_pop     = emit && last;
    assign digit_idx = step_reg[3:1];
    assign ind_mask  = 8'd1 << head.ind_bit;

    always_comb
    begin
        addr     = '0;
        value    = '0;
        clr      = 1'b0;
        last     = 1'b1;
        glyph    = head.glyph;
        char_pos = head.position;
        current  = '0;
        pattern  = '0;
        unique case (head.kind)
            seglcd_pkg::KIND_CLEAR:
            begin
                clr = 1'b1;
            end
            seglcd_pkg::KIND_CHAR, seglcd_pkg::KIND_NUMBER:
            begin
                if (head.kind == seglcd_pkg::KIND_NUMBER) begin
                    char_pos = 3'd6 - digit_idx;
                    glyph    = {2'b00, head.bcd[{digit_idx, 2'b00} +: 4]};
                end
                pattern = seglcd_pkg::glyph_pattern(glyph);
                if (head.kind == seglcd_pkg::KIND_NUMBER && digit_idx == head.count) begin
                    // Sign beat after the digits; it sees any digit just written to its byte
                    addr    = seglcd_pkg::SIGN_BYTE;
                    current = image_reg[IDX_W'(seglcd_pkg::SIGN_BYTE - 5'd1)];
                    value   = head.neg ? (current | seglcd_pkg::SIGN_MASK)
                                       : (current & ~seglcd_pkg::SIGN_MASK);
                end else begin
                    addr  = seglcd_pkg::pos_byte(char_pos) + {4'd0, step_reg[0]};
                    value = step_reg[0] ? pattern[7:0] : pattern[15:8];
                    last  = step_reg[0] && (head.kind == seglcd_pkg::KIND_CHAR);
                end
            end
            seglcd_pkg::KIND_IND:
            begin
                addr    = head.ind_addr;
                current = image_reg[IDX_W'(head.ind_addr - 5'd1)];
                value   = head.ind_on ? (current | ind_mask) : (current & ~ind_mask);
            end
            default:
            begin
                clr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            for (int i = 0; i < IMAGE_BYTES; i++) begin
                image_reg[i] <= '0;
            end
        end else begin
            if (emit) begin
                out_valid_reg <= 1'b1;
                step_reg      <= last ? 4'd0 : step_reg + 4'd1;
                if (clr) begin
                    for (int i = 0; i < IMAGE_BYTES; i++) begin
                        image_reg[i] <= '0;
                    end
                end else begin
                    image_reg[IDX_W'(addr - 5'd1)] <= value;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            addr_reg  <= addr;
            value_reg <= value;
            clear_reg <= clr;
            last_reg  <= last;
        end
    end

    assign empty        = !out_valid_reg;
    assign byte_address = addr_reg;
    assign byte_value   = value_reg;
    assign clear_all    = clear_reg;
    assign last_write   = last_reg;

endmodule

`default_nettype wire

[hw/rtl/segment_lcd_text_and_number_driver_core.sv]
// Top level of the six-character fourteen-segment LCD image driver.
// Input beats are taken on the push/full queue interface: a beat is accepted at a clock
// edge where push is high and full is low. Each beat clears the image, draws a character,
// shows a signed integer or changes an indicator segment. Every LCD byte changed is
// reported as one result beat on the empty/pop interface, in order, with last_write set
// on the final beat caused by an input beat; a clear gives a single beat with clear_all.
// Beats that write nothing (position out of range, indicator index above fifteen) give
// no result. The front end takes one beat per cycle for characters, indicators and
// clears while the queue is not full; an integer holds it through the binary to decimal
// conversion, two magnitude bits per cycle, until it is queued. The back end issues one
// byte write per cycle while the output is not held: two per character, up to thirteen
// for an integer. A two-entry command queue lets the front end convert the next integer
// while the back end is still writing. When pop stays low the output register holds its
// beat, the back end waits and, once the queue fills, full rises. Reset clears the image
// to zero and empties all stages.
`default_nettype none

module segment_lcd_text_and_number_driver_core #(
    parameter int DIGIT_COUNT = seglcd_pkg::DIGIT_COUNT_DEF,
    parameter int IMAGE_BYTES = seglcd_pkg::IMAGE_BYTES_DEF,
    parameter int QUEUE_DEPTH = seglcd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [1:0]          opcode,
    input  wire logic [2:0]          position,
    input  wire logic [7:0]          code,
    input  wire logic signed [31:0]  number,
    input  wire logic                indicator_on,
    output logic                     empty,
    input  wire logic                pop,
    output logic [4:0]               byte_address,
    output logic [7:0]               byte_value,
    output logic                     clear_all,
    output logic                     last_write
);

    // Command handshake between the front end, the queue and the back end
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    seglcd_pkg::cmd_t q_data;
    seglcd_pkg::cmd_t q_head;

    seglcd_front #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .position     (position),
        .code         (code),
        .number       (number),
        .indicator_on (indicator_on),
        .q_push       (q_push),
        .q_data       (q_data),
        .q_full       (q_full)
    );

    seglcd_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    seglcd_back #(
        .IMAGE_BYTES (IMAGE_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .byte_address (byte_address),
        .byte_value   (byte_value),
        .clear_all    (clear_all),
        .last_write   (last_write)
    );

    // The front end must never offer a command that the queue cannot take.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    // The back end retires a command only when one is waiting.
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command retired from an empty queue");

    // A clear is a single beat at address zero that closes its item.
    a_clear_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && clear_all) |-> (byte_address == 5'd0 && byte_value == 8'd0 && last_write))
        else $error("clear beat with a stray address, value or missing last mark");

    // A beat that writes a byte always names an LCD byte in the image.
    a_address_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !clear_all) |->
            (byte_address >= 5'd1 && 6'(byte_address) <= 6'(IMAGE_BYTES)))
        else $error("byte write outside the LCD image");

endmodule

`default_nettype wire
